>>> hdl/mbpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbpa_pkg;

   // Default pool depths.
   localparam int H264_DEPTH_DEF    = 16;
   localparam int AUDIO_DEPTH_DEF   = 16;
   localparam int MOTION_DEPTH_DEF  = 16;
   localparam int JPEG_DEPTH_DEF    = 16;
   localparam int PREVIEW_DEPTH_DEF = 8;

   // Pool codes on the request port.
   localparam logic [2:0] POOL_H264    = 3'd0;
   localparam logic [2:0] POOL_PREVIEW = 3'd1;
   localparam logic [2:0] POOL_AUDIO   = 3'd2;
   localparam logic [2:0] POOL_MOTION  = 3'd3;
   localparam logic [2:0] POOL_JPEG    = 3'd4;

   // Preview size formats.
   localparam logic [1:0] FMT_D1     = 2'd0;
   localparam logic [1:0] FMT_CIF    = 2'd1;
   localparam logic [1:0] FMT_QCIF   = 2'd2;
   localparam logic [1:0] FMT_UNUSED = 2'd3;

   // Initial slot maps of a freshly claimed preview buffer.
   localparam logic [15:0] MAP_D1   = 16'hffff;
   localparam logic [15:0] MAP_CIF  = 16'h000f;
   localparam logic [15:0] MAP_QCIF = 16'h0001;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_WARN     = 3'd1,
      ST_NONE     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_BADPOOL  = 3'd4,
      ST_BADFMT   = 3'd5
   } status_type;

   // Pool selected for a command travelling down the chain.
   typedef enum logic [2:0] {
      SEL_H264    = 3'd0,
      SEL_AUDIO   = 3'd1,
      SEL_MOTION  = 3'd2,
      SEL_JPEG    = 3'd3,
      SEL_PREVIEW = 3'd4
   } sel_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_RUN,
      FSM_WAIT
   } fsm_type;

   // Command token handed from cell to cell.
   typedef struct packed {
      logic        active;
      logic        oper;
      sel_type     sel;
      logic [1:0]  fmt;
      logic [5:0]  idx;
      logic [3:0]  slot;
      logic        pass2;
      logic        hit;
      logic        warn;
      logic        nf;
      logic        freed;
      logic [5:0]  ent;
      logic [3:0]  gslot;
   } tok_type;

   // Result waiting for the response register.
   typedef struct packed {
      status_type  status;
      logic [5:0]  ent;
      logic [3:0]  gslot;
      logic [6:0]  left;
   } res_type;

   function automatic int max5(input int a, input int b, input int c, input int d,
                               input int e);
      int m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      if (d > m) m = d;
      if (e > m) m = e;
      return m;
   endfunction

endpackage

`default_nettype wire

>>> hdl/mbpa_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mbpa_cell #(
   parameter int IDX           = 0,
   parameter int H264_DEPTH    = mbpa_pkg::H264_DEPTH_DEF,
   parameter int AUDIO_DEPTH   = mbpa_pkg::AUDIO_DEPTH_DEF,
   parameter int MOTION_DEPTH  = mbpa_pkg::MOTION_DEPTH_DEF,
   parameter int JPEG_DEPTH    = mbpa_pkg::JPEG_DEPTH_DEF,
   parameter int PREVIEW_DEPTH = mbpa_pkg::PREVIEW_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mbpa_pkg::tok_type tok_i,
   output mbpa_pkg::tok_type      tok_o
);

   // Which pools own an entry at this position.
   localparam logic [3:0] HAS_PLAIN = {
      (IDX < JPEG_DEPTH), (IDX < MOTION_DEPTH), (IDX < AUDIO_DEPTH), (IDX < H264_DEPTH)
   };
   localparam logic HAS_PV = (IDX < PREVIEW_DEPTH);
   localparam logic [5:0] MY_IDX = 6'(IDX);

   logic [3:0]        busy_ff, busy_in;
   logic [1:0]        fmt_ff, fmt_in;
   logic [15:0]       map_ff, map_in;
   mbpa_pkg::tok_type tok_ff, tok_in;

   logic        nib_free, bit_free;
   logic [1:0]  nib_sel;
   logic [3:0]  bit_sel;
   logic [15:0] rel_mask;
   logic [1:0]  k;

   // Lowest free nibble and lowest free bit of this buffer's map.
   always_comb begin
      nib_free = 1'b0;
      nib_sel  = 2'd0;
      for (int j = 3; j >= 0; j--) begin
         if (map_ff[4*j +: 4] == 4'h0) begin
            nib_free = 1'b1;
            nib_sel  = 2'(j);
         end
      end
      bit_free = 1'b0;
      bit_sel  = 4'd0;
      for (int j = 15; j >= 0; j--) begin
         if (!map_ff[j]) begin
            bit_free = 1'b1;
            bit_sel  = 4'(j);
         end
      end
   end

   // Act on the passing token and update the local entry.
   always_comb begin
      tok_in   = tok_i;
      busy_in  = busy_ff;
      fmt_in   = fmt_ff;
      map_in   = map_ff;
      k        = tok_i.sel[1:0];
      rel_mask = 16'h0000;
      if (tok_i.fmt == mbpa_pkg::FMT_CIF) begin
         rel_mask = 16'h000f << {tok_i.slot[1:0], 2'b00};
      end else begin
         rel_mask = 16'h0001 << tok_i.slot;
      end
      if (tok_i.active) begin
         if (tok_i.sel != mbpa_pkg::SEL_PREVIEW) begin
            if (HAS_PLAIN[k]) begin
               if (tok_i.oper == mbpa_pkg::OP_ALLOC) begin
                  if (!tok_i.hit && !busy_ff[k]) begin
                     busy_in[k] = 1'b1;
                     tok_in.hit = 1'b1;
                     tok_in.ent = MY_IDX;
                  end
               end else if (tok_i.idx == MY_IDX) begin
                  tok_in.hit  = 1'b1;
                  tok_in.warn = !busy_ff[k];
                  busy_in[k]  = 1'b0;
               end
            end
         end else if (HAS_PV) begin
            if (tok_i.oper == mbpa_pkg::OP_ALLOC) begin
               if (!tok_i.hit && !tok_i.pass2 && fmt_ff == tok_i.fmt) begin
                  if (tok_i.fmt == mbpa_pkg::FMT_CIF && nib_free) begin
                     map_in[{nib_sel, 2'b00} +: 4] = 4'hf;
                     tok_in.hit   = 1'b1;
                     tok_in.ent   = MY_IDX;
                     tok_in.gslot = {2'b00, nib_sel};
                  end else if (tok_i.fmt == mbpa_pkg::FMT_QCIF && bit_free) begin
                     map_in[bit_sel] = 1'b1;
                     tok_in.hit   = 1'b1;
                     tok_in.ent   = MY_IDX;
                     tok_in.gslot = bit_sel;
                  end
               end else if (!tok_i.hit && tok_i.pass2 && fmt_ff == mbpa_pkg::FMT_UNUSED) begin
                  fmt_in = tok_i.fmt;
                  case (tok_i.fmt)
                     mbpa_pkg::FMT_D1:  map_in = mbpa_pkg::MAP_D1;
                     mbpa_pkg::FMT_CIF: map_in = mbpa_pkg::MAP_CIF;
                     default:           map_in = mbpa_pkg::MAP_QCIF;
                  endcase
                  tok_in.hit   = 1'b1;
                  tok_in.ent   = MY_IDX;
                  tok_in.gslot = 4'd0;
               end
            end else if (tok_i.idx == MY_IDX) begin
               tok_in.hit = 1'b1;
               if (fmt_ff != tok_i.fmt) begin
                  tok_in.nf = 1'b1;
               end else if (tok_i.fmt == mbpa_pkg::FMT_D1) begin
                  if (tok_i.slot != 4'd0) begin
                     tok_in.nf = 1'b1;
                  end else begin
                     tok_in.warn  = (map_ff != mbpa_pkg::MAP_D1);
                     tok_in.freed = 1'b1;
                     fmt_in       = mbpa_pkg::FMT_UNUSED;
                     map_in       = 16'h0000;
                  end
               end else if (tok_i.fmt == mbpa_pkg::FMT_CIF && tok_i.slot[3:2] != 2'b00) begin
                  tok_in.nf = 1'b1;
               end else begin
                  tok_in.warn = ((map_ff & rel_mask) == 16'h0000);
                  map_in      = map_ff & ~rel_mask;
                  if (map_in == 16'h0000) begin
                     tok_in.freed = 1'b1;
                     fmt_in       = mbpa_pkg::FMT_UNUSED;
                  end
               end
            end
         end
      end
   end

   // Entry state and the token register toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 4'h0;
         fmt_ff        <= mbpa_pkg::FMT_UNUSED;
         map_ff        <= 16'h0000;
         tok_ff.active <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         fmt_ff        <= fmt_in;
         map_ff        <= map_in;
         tok_ff.active <= tok_in.active;
      end
      tok_ff.oper    <= tok_in.oper;
      tok_ff.sel     <= tok_in.sel;
      tok_ff.fmt     <= tok_in.fmt;
      tok_ff.idx     <= tok_in.idx;
      tok_ff.slot    <= tok_in.slot;
      tok_ff.pass2   <= tok_in.pass2;
      tok_ff.hit     <= tok_in.hit;
      tok_ff.warn    <= tok_in.warn;
      tok_ff.nf      <= tok_in.nf;
      tok_ff.freed   <= tok_in.freed;
      tok_ff.ent     <= tok_in.ent;
      tok_ff.gslot   <= tok_in.gslot;
   end

   assign tok_o = tok_ff;

   // A claimed preview buffer always carries a non-empty slot map.
   a_map_nonempty: assert property (@(posedge clock) disable iff (reset)
      (fmt_ff != mbpa_pkg::FMT_UNUSED) |-> (map_ff != 16'h0000))
      else $error("used preview buffer with empty map");

   // An unused preview buffer has a clear map.
   a_unused_clear: assert property (@(posedge clock) disable iff (reset)
      (fmt_ff == mbpa_pkg::FMT_UNUSED) |-> (map_ff == 16'h0000))
      else $error("unused preview buffer with slots set");

   // A D1 buffer is always completely full.
   a_d1_full: assert property (@(posedge clock) disable iff (reset)
      (fmt_ff == mbpa_pkg::FMT_D1) |-> (map_ff == mbpa_pkg::MAP_D1))
      else $error("D1 buffer map not full");

endmodule

`default_nettype wire

>>> hdl/media_buffer_pool_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals
// req       in         req_valid, req_ready, req_operation, req_pool, req_size_format,
//                      req_entry_index, req_slot_index
// rsp       out        rsp_valid, rsp_ready, rsp_status, rsp_granted_entry,
//                      rsp_granted_slot, rsp_free_left
//
// Requests rejected up front (bad pool, bad format, range error, empty counter) skip
// the chain and go straight to the response. Others walk a token down a chain of N
// cells (N = largest pool depth); a preview allocation that finds no partly used
// buffer walks the chain twice.
// Reset is synchronous and frees every entry. One request is in work at a time; a new
// request is taken while a finished response still waits for rsp_ready.

module media_buffer_pool_allocator #(
   parameter int H264_DEPTH    = mbpa_pkg::H264_DEPTH_DEF,
   parameter int AUDIO_DEPTH   = mbpa_pkg::AUDIO_DEPTH_DEF,
   parameter int MOTION_DEPTH  = mbpa_pkg::MOTION_DEPTH_DEF,
   parameter int JPEG_DEPTH    = mbpa_pkg::JPEG_DEPTH_DEF,
   parameter int PREVIEW_DEPTH = mbpa_pkg::PREVIEW_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_operation,
   input  wire logic [2:0] req_pool,
   input  wire logic [1:0] req_size_format,
   input  wire logic [5:0] req_entry_index,
   input  wire logic [3:0] req_slot_index,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status,
   output logic [5:0]      rsp_granted_entry,
   output logic [3:0]      rsp_granted_slot,
   output logic [6:0]      rsp_free_left
);

   localparam int CHAIN_LEN = mbpa_pkg::max5(H264_DEPTH, AUDIO_DEPTH, MOTION_DEPTH,
                                             JPEG_DEPTH, PREVIEW_DEPTH);
   localparam logic [3:0][6:0] PLAIN_DEPTHS = {
      7'(JPEG_DEPTH), 7'(MOTION_DEPTH), 7'(AUDIO_DEPTH), 7'(H264_DEPTH)
   };
   localparam logic [6:0] PV_DEPTH = 7'(PREVIEW_DEPTH);

   mbpa_pkg::fsm_type state_ff, state_in;
   mbpa_pkg::tok_type tok_ff, tok_in;
   mbpa_pkg::tok_type link [CHAIN_LEN+1];
   mbpa_pkg::res_type res_ff, res_in;
   logic              inject_ff, inject_in;
   logic [3:0][6:0]   cnt_ff, cnt_in;
   logic [6:0]        pv_cnt_ff, pv_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mbpa_pkg::res_type rsp_ff;
   mbpa_pkg::sel_type req_sel;
   logic              req_bad;
   logic [1:0]        rk, ok;
   mbpa_pkg::tok_type co;

   // Chain of entry cells.
   always_comb begin
      link[0]        = tok_ff;
      link[0].active = inject_ff;
   end

   for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
      mbpa_cell #(
         .IDX           (i),
         .H264_DEPTH    (H264_DEPTH),
         .AUDIO_DEPTH   (AUDIO_DEPTH),
         .MOTION_DEPTH  (MOTION_DEPTH),
         .JPEG_DEPTH    (JPEG_DEPTH),
         .PREVIEW_DEPTH (PREVIEW_DEPTH)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (link[i]),
         .tok_o (link[i+1])
      );
   end

   assign co = link[CHAIN_LEN];

   // Pool decode of the request.
   always_comb begin
      req_bad = 1'b0;
      case (req_pool)
         mbpa_pkg::POOL_H264:    req_sel = mbpa_pkg::SEL_H264;
         mbpa_pkg::POOL_PREVIEW: req_sel = mbpa_pkg::SEL_PREVIEW;
         mbpa_pkg::POOL_AUDIO:   req_sel = mbpa_pkg::SEL_AUDIO;
         mbpa_pkg::POOL_MOTION:  req_sel = mbpa_pkg::SEL_MOTION;
         mbpa_pkg::POOL_JPEG:    req_sel = mbpa_pkg::SEL_JPEG;
         default: begin
            req_sel = mbpa_pkg::SEL_H264;
            req_bad = 1'b1;
         end
      endcase
   end

   assign rk = req_sel[1:0];
   assign ok = co.sel[1:0];

   // Sequencer: front-end checks, token launch, completion and response hand-off.
   always_comb begin
      state_in     = state_ff;
      tok_in       = tok_ff;
      inject_in    = 1'b0;
      res_in       = res_ff;
      cnt_in       = cnt_ff;
      pv_cnt_in    = pv_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = (state_ff == mbpa_pkg::FSM_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mbpa_pkg::FSM_IDLE: begin
            if (req_valid) begin
               tok_in.active  = 1'b0;
               tok_in.oper    = req_operation;
               tok_in.sel     = req_sel;
               tok_in.fmt     = req_size_format;
               tok_in.idx     = req_entry_index;
               tok_in.slot    = req_slot_index;
               tok_in.pass2   = 1'b0;
               tok_in.hit     = 1'b0;
               tok_in.warn    = 1'b0;
               tok_in.nf      = 1'b0;
               tok_in.freed   = 1'b0;
               tok_in.ent     = 6'd0;
               tok_in.gslot   = 4'd0;
               res_in.ent     = 6'd0;
               res_in.gslot   = 4'd0;
               state_in       = mbpa_pkg::FSM_WAIT;
               if (req_bad) begin
                  res_in.status = mbpa_pkg::ST_BADPOOL;
                  res_in.left   = 7'd0;
               end else if (req_sel == mbpa_pkg::SEL_PREVIEW) begin
                  res_in.left = pv_cnt_ff;
                  if (req_size_format == mbpa_pkg::FMT_UNUSED) begin
                     res_in.status = mbpa_pkg::ST_BADFMT;
                  end else if (req_operation == mbpa_pkg::OP_RELEASE &&
                               {1'b0, req_entry_index} >= PV_DEPTH) begin
                     res_in.status = mbpa_pkg::ST_NOTFOUND;
                  end else begin
                     inject_in = 1'b1;
                     state_in  = mbpa_pkg::FSM_RUN;
                  end
               end else begin
                  res_in.left = cnt_ff[rk];
                  if (req_operation == mbpa_pkg::OP_ALLOC && cnt_ff[rk] == 7'd0) begin
                     res_in.status = mbpa_pkg::ST_NONE;
                  end else if (req_operation == mbpa_pkg::OP_RELEASE &&
                               {1'b0, req_entry_index} >= PLAIN_DEPTHS[rk]) begin
                     res_in.status = mbpa_pkg::ST_NOTFOUND;
                  end else begin
                     inject_in = 1'b1;
                     state_in  = mbpa_pkg::FSM_RUN;
                  end
               end
            end
         end
         mbpa_pkg::FSM_RUN: begin
            if (co.active) begin
               res_in.ent   = 6'd0;
               res_in.gslot = 4'd0;
               state_in     = mbpa_pkg::FSM_WAIT;
               if (co.sel == mbpa_pkg::SEL_PREVIEW) begin
                  if (co.oper == mbpa_pkg::OP_ALLOC) begin
                     if (!co.hit && !co.pass2) begin
                        // No partly used buffer: look for an unused one.
                        tok_in.pass2 = 1'b1;
                        inject_in    = 1'b1;
                        state_in     = mbpa_pkg::FSM_RUN;
                     end else if (co.hit) begin
                        res_in.status = mbpa_pkg::ST_OK;
                        res_in.ent    = co.ent;
                        res_in.gslot  = co.gslot;
                        if (co.pass2 && pv_cnt_ff != 7'd0) begin
                           pv_cnt_in = pv_cnt_ff - 7'd1;
                        end
                     end else begin
                        res_in.status = mbpa_pkg::ST_NONE;
                     end
                  end else if (co.nf) begin
                     res_in.status = mbpa_pkg::ST_NOTFOUND;
                  end else begin
                     res_in.status = co.warn ? mbpa_pkg::ST_WARN : mbpa_pkg::ST_OK;
                     if (co.freed && pv_cnt_ff < PV_DEPTH) begin
                        pv_cnt_in = pv_cnt_ff + 7'd1;
                     end
                  end
                  res_in.left = pv_cnt_in;
               end else begin
                  if (co.oper == mbpa_pkg::OP_ALLOC) begin
                     if (co.hit) begin
                        res_in.status = mbpa_pkg::ST_OK;
                        res_in.ent    = co.ent;
                        cnt_in[ok]    = cnt_ff[ok] - 7'd1;
                     end else begin
                        res_in.status = mbpa_pkg::ST_NONE;
                     end
                  end else begin
                     res_in.status = co.warn ? mbpa_pkg::ST_WARN : mbpa_pkg::ST_OK;
                     if (cnt_ff[ok] < PLAIN_DEPTHS[ok]) begin
                        cnt_in[ok] = cnt_ff[ok] + 7'd1;
                     end
                  end
                  res_in.left = cnt_in[ok];
               end
            end
         end
         mbpa_pkg::FSM_WAIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = mbpa_pkg::FSM_IDLE;
            end
         end
         default: state_in = mbpa_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbpa_pkg::FSM_IDLE;
         inject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= PLAIN_DEPTHS;
         pv_cnt_ff    <= PV_DEPTH;
      end else begin
         state_ff     <= state_in;
         inject_ff    <= inject_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         pv_cnt_ff    <= pv_cnt_in;
      end
      tok_ff <= tok_in;
      res_ff <= res_in;
      if (state_ff == mbpa_pkg::FSM_WAIT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_granted_entry = rsp_ff.ent;
   assign rsp_granted_slot  = rsp_ff.gslot;
   assign rsp_free_left     = rsp_ff.left;

   // A token leaves the chain only while a command is in work.
   a_token_run: assert property (@(posedge clock) disable iff (reset)
      co.active |-> (state_ff == mbpa_pkg::FSM_RUN))
      else $error("token out of chain outside run state");

   // Free counters never pass their pool depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[0] <= PLAIN_DEPTHS[0]) && (cnt_ff[1] <= PLAIN_DEPTHS[1]) &&
      (cnt_ff[2] <= PLAIN_DEPTHS[2]) && (cnt_ff[3] <= PLAIN_DEPTHS[3]) &&
      (pv_cnt_ff <= PV_DEPTH))
      else $error("free counter above pool depth");

   // A transfer on the request side always starts work.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != mbpa_pkg::FSM_IDLE))
      else $error("request taken but sequencer idle");

   // A launched token is only launched from the run state path.
   a_inject: assert property (@(posedge clock) disable iff (reset)
      inject_ff |-> (state_ff == mbpa_pkg::FSM_RUN))
      else $error("token launched outside run state");

endmodule

`default_nettype wire
